// ===== hdl/srm_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI register access master - shared package
// Item and result records, function codes and default sizing.
// ----------------------------------------------------------------------------
package srm_pkg;

  // default depth of the transmit byte buffer
  localparam int MAX_BYTES_DEF = 8;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_LOAD  = 2'd0;
  localparam func_t FUNC_START = 2'd1;
  localparam func_t FUNC_TICK  = 2'd2;

  typedef struct packed {
    func_t       func;
    logic        device;
    logic        is_read;
    logic [6:0]  reg_addr;
    logic [3:0]  burst_len;
    logic [7:0]  wr_byte;
    logic        miso_ag;
    logic        miso_m;
  } item_t;

  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        cs_ag_n;
    logic        cs_m_n;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic        busy_res;
    logic        rejected;
  } result_t;

endpackage

// ===== hdl/srm_txbuf.sv =====
// ----------------------------------------------------------------------------
// SPI register access master - transmit byte buffer
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module srm_txbuf #(
  parameter int MAX_BYTES = srm_pkg::MAX_BYTES_DEF,
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data_r
);

  logic [7:0] mem [MAX_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read address follows the next byte index, so the registered data matches that index once the step is taken
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== hdl/srm_core.sv =====
// ----------------------------------------------------------------------------
// SPI register access master - sequencer
// Transaction state and pin levels; one item is applied per step.
// ----------------------------------------------------------------------------
module srm_core #(
  parameter int MAX_BYTES = srm_pkg::MAX_BYTES_DEF,
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
  localparam int CNT_W = $clog2(MAX_BYTES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  srm_pkg::item_t    item,
  input  logic [7:0]        rd_data,
  output logic [IDX_W-1:0]  rd_addr,
  output logic              wr_en,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [7:0]        wr_data,
  output srm_pkg::result_t  res_nxt
);

  logic             active_r,      active_nxt;
  logic             sel_device_r,  sel_device_nxt;
  logic             read_mode_r,   read_mode_nxt;
  logic [7:0]       header_r,      header_nxt;
  logic [CNT_W-1:0] fill_count_r,  fill_count_nxt;
  logic [CNT_W-1:0] bytes_left_r,  bytes_left_nxt;
  logic [CNT_W-1:0] byte_index_r,  byte_index_nxt;
  logic [2:0]       bit_index_r,   bit_index_nxt;
  logic             in_header_r,   in_header_nxt;
  logic             half_phase_r,  half_phase_nxt;
  logic [7:0]       rx_shift_r,    rx_shift_nxt;
  logic             sck_r,         sck_nxt;
  logic             mosi_r,        mosi_nxt;
  logic             cs_ag_r,       cs_ag_nxt;
  logic             cs_m_r,        cs_m_nxt;
  logic             rejected;
  logic             rx_valid;
  logic             rx_last;
  logic             cs_sel;
  logic             miso_bit;

  assign cs_sel   = sel_device_r ? cs_m_r : cs_ag_r;
  assign miso_bit = sel_device_r ? item.miso_m : item.miso_ag;
  assign wr_addr  = fill_count_r[IDX_W-1:0];
  assign wr_data  = item.wr_byte;

  always_comb begin
    active_nxt     = active_r;
    sel_device_nxt = sel_device_r;
    read_mode_nxt  = read_mode_r;
    header_nxt     = header_r;
    fill_count_nxt = fill_count_r;
    bytes_left_nxt = bytes_left_r;
    byte_index_nxt = byte_index_r;
    bit_index_nxt  = bit_index_r;
    in_header_nxt  = in_header_r;
    half_phase_nxt = half_phase_r;
    rx_shift_nxt   = rx_shift_r;
    sck_nxt        = sck_r;
    mosi_nxt       = mosi_r;
    cs_ag_nxt      = cs_ag_r;
    cs_m_nxt       = cs_m_r;
    rejected       = 1'b0;
    rx_valid       = 1'b0;
    rx_last        = 1'b0;
    wr_en          = 1'b0;

    case (item.func)
      srm_pkg::FUNC_LOAD: begin
        if (active_r || (fill_count_r >= CNT_W'(MAX_BYTES))) begin
          rejected = 1'b1;
        end else begin
          wr_en          = step;
          fill_count_nxt = fill_count_r + CNT_W'(1);
        end
      end
      srm_pkg::FUNC_START: begin
        if (active_r) begin
          rejected = 1'b1;
        end else begin
          active_nxt     = 1'b1;
          sel_device_nxt = item.device;
          read_mode_nxt  = item.is_read;
          header_nxt     = {item.is_read, item.reg_addr};
          bytes_left_nxt = (32'(item.burst_len) > 32'(MAX_BYTES)) ?
                           CNT_W'(MAX_BYTES) : CNT_W'(item.burst_len);
          byte_index_nxt = '0;
          bit_index_nxt  = '0;
          in_header_nxt  = 1'b1;
          half_phase_nxt = 1'b0;
          rx_shift_nxt   = '0;
          if (!item.is_read) begin
            fill_count_nxt = '0;
          end
        end
      end
      srm_pkg::FUNC_TICK: begin
        if (active_r) begin
          if (cs_sel) begin
            if (sel_device_r) cs_m_nxt = 1'b0;
            else              cs_ag_nxt = 1'b0;
          end else if (!in_header_r && (bytes_left_r == '0)) begin
            if (sel_device_r) cs_m_nxt = 1'b1;
            else              cs_ag_nxt = 1'b1;
            active_nxt     = 1'b0;
            half_phase_nxt = 1'b0;
          end else if (!half_phase_r) begin
            // falling edge: drive the next data bit
            sck_nxt = 1'b0;
            if (in_header_r) begin
              mosi_nxt = header_r[7];
            end else if (!read_mode_r) begin
              mosi_nxt = rd_data[3'd7 - bit_index_r];
            end
            half_phase_nxt = 1'b1;
          end else begin
            // rising edge: sample and advance the bit counters
            sck_nxt        = 1'b1;
            half_phase_nxt = 1'b0;
            bit_index_nxt  = bit_index_r + 3'd1;
            if (in_header_r) begin
              header_nxt = {header_r[6:0], 1'b0};
              if (bit_index_r == 3'd7) begin
                in_header_nxt = 1'b0;
              end
            end else begin
              if (read_mode_r) begin
                rx_shift_nxt = {rx_shift_r[6:0], miso_bit};
              end
              if (bit_index_r == 3'd7) begin
                byte_index_nxt = byte_index_r + CNT_W'(1);
                bytes_left_nxt = bytes_left_r - CNT_W'(1);
                if (read_mode_r) begin
                  rx_valid = 1'b1;
                  rx_last  = (bytes_left_nxt == '0);
                end
              end
            end
          end
        end
      end
      default: begin
        rejected = 1'b1;
      end
    endcase
  end

  assign rd_addr = byte_index_nxt[IDX_W-1:0];

  always_comb begin
    res_nxt.sck      = sck_nxt;
    res_nxt.mosi     = mosi_nxt;
    res_nxt.cs_ag_n  = cs_ag_nxt;
    res_nxt.cs_m_n   = cs_m_nxt;
    res_nxt.rx_valid = rx_valid;
    res_nxt.rx_byte  = rx_valid ? rx_shift_nxt : 8'd0;
    res_nxt.rx_last  = rx_last;
    res_nxt.busy_res = active_nxt;
    res_nxt.rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      sel_device_r <= 1'b0;
      read_mode_r  <= 1'b0;
      header_r     <= '0;
      fill_count_r <= '0;
      bytes_left_r <= '0;
      byte_index_r <= '0;
      bit_index_r  <= '0;
      in_header_r  <= 1'b0;
      half_phase_r <= 1'b0;
      rx_shift_r   <= '0;
      sck_r        <= 1'b1;
      mosi_r       <= 1'b0;
      cs_ag_r      <= 1'b1;
      cs_m_r       <= 1'b1;
    end else if (step) begin
      active_r     <= active_nxt;
      sel_device_r <= sel_device_nxt;
      read_mode_r  <= read_mode_nxt;
      header_r     <= header_nxt;
      fill_count_r <= fill_count_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_index_r <= byte_index_nxt;
      bit_index_r  <= bit_index_nxt;
      in_header_r  <= in_header_nxt;
      half_phase_r <= half_phase_nxt;
      rx_shift_r   <= rx_shift_nxt;
      sck_r        <= sck_nxt;
      mosi_r       <= mosi_nxt;
      cs_ag_r      <= cs_ag_nxt;
      cs_m_r       <= cs_m_nxt;
    end
  end

  a_one_cs: assert property (@(posedge clk) disable iff (!rst_n)
    cs_ag_r || cs_m_r)
    else $error("both chip selects asserted");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (sck_r && cs_ag_r && cs_m_r))
    else $error("bus not idle while no transaction");

  a_rx_read: assert property (@(posedge clk) disable iff (!rst_n)
    (step && rx_valid) |-> (active_r && read_mode_r && !in_header_r))
    else $error("received byte outside read data phase");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!active_r && (fill_count_r < CNT_W'(MAX_BYTES))))
    else $error("buffer write while busy or full");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= CNT_W'(MAX_BYTES))
    else $error("byte count beyond buffer depth");

endmodule

// ===== hdl/spi_register_access_master_top.sv =====
// ----------------------------------------------------------------------------
// SPI register access master - top level
// Mode 3 SPI master for register bursts on two chip selects.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one command per transfer: load a write byte,
//   start a burst (device, direction, address, byte count) or a half-bit
//   tick. Every accepted command yields exactly one transfer on the out_
//   channel with the pin levels after the command, any received byte and
//   the busy and rejected flags.
//   Path: a command is captured in the input register and its result is
//   written to the output register once that is free; out_valid rises
//   with that write.
//   Throughput: one command per cycle while out_ready is high; the sequencer
//   applies one command per cycle with short logic between the input and output
//   registers. Stalls: when out_ready is low the result holds, the input
//   register fills and in_ready drops until the result is taken.
//   Reset: rst_n clears the sequencer; sck and both chip selects go high,
//   mosi low, the write buffer count to zero. Buffer contents are kept.
// ----------------------------------------------------------------------------
module spi_register_access_master_top #(
  parameter int MAX_BYTES = srm_pkg::MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic       in_device,
  input  logic       in_is_read,
  input  logic [6:0] in_reg_addr,
  input  logic [3:0] in_burst_len,
  input  logic [7:0] in_wr_byte,
  input  logic       in_miso_ag,
  input  logic       in_miso_m,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_sck,
  output logic       out_mosi,
  output logic       out_cs_ag_n,
  output logic       out_cs_m_n,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_last,
  output logic       out_busy_res,
  output logic       out_rejected
);

  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic              in_hold_r;
  srm_pkg::item_t    item_r;
  logic              out_valid_r;
  srm_pkg::result_t  res_r;
  srm_pkg::result_t  res_nxt;
  logic              step;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [7:0]        rd_data;

  assign step     = in_hold_r && (!out_valid_r || out_ready);
  assign in_ready = !in_hold_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hold_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_hold_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.func      <= in_func;
      item_r.device    <= in_device;
      item_r.is_read   <= in_is_read;
      item_r.reg_addr  <= in_reg_addr;
      item_r.burst_len <= in_burst_len;
      item_r.wr_byte   <= in_wr_byte;
      item_r.miso_ag   <= in_miso_ag;
      item_r.miso_m    <= in_miso_m;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  srm_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (item_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res_nxt (res_nxt)
  );

  srm_txbuf #(
    .MAX_BYTES (MAX_BYTES)
  ) u_txbuf (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign out_valid    = out_valid_r;
  assign out_sck      = res_r.sck;
  assign out_mosi     = res_r.mosi;
  assign out_cs_ag_n  = res_r.cs_ag_n;
  assign out_cs_m_n   = res_r.cs_m_n;
  assign out_rx_valid = res_r.rx_valid;
  assign out_rx_byte  = res_r.rx_byte;
  assign out_rx_last  = res_r.rx_last;
  assign out_busy_res = res_r.busy_res;
  assign out_rejected = res_r.rejected;

endmodule

// ===== verif/spi_register_access_master_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI register access master - block test
// Drives load, start and tick commands through the in_ channel and compares
// every out_ transfer with a cycle-free model of the burst sequencer kept in
// a scoreboard. Directed corner cases come first, then random bursts with
// random idle and stall periods on both channels.
// ----------------------------------------------------------------------------
module spi_register_access_master_top_test;

  localparam int MAX_BYTES = srm_pkg::MAX_BYTES_DEF;
  localparam int IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam srm_pkg::func_t FUNC_UNUSED = 2'd3;
  localparam int RANDOM_CMDS = 1000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [7:0] EDGE_BYTES [0:7] =
    '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE};

  // Burst sequencer model plus the queue of pin states still to arrive.
  class burst_scoreboard;
    logic [7:0] tx_buf [MAX_BYTES];
    int unsigned loaded_upto;  // entries below this were written since reset
    logic [3:0] fill;
    bit active, dev_sel, rd_mode, in_hdr, half_hi;
    logic [7:0] hdr_sr, rx_sr;
    logic [3:0] left, byte_idx, bit_idx;
    bit sck, mosi, cs_ag, cs_m;
    srm_pkg::result_t pin_expect_q[$];
    int unsigned errors, checked, bursts, rx_bytes, ignored;

    function new();
      loaded_upto = 0;
      fill = '0;
      active = 0; dev_sel = 0; rd_mode = 0; in_hdr = 0; half_hi = 0;
      hdr_sr = '0; rx_sr = '0;
      left = '0; byte_idx = '0; bit_idx = '0;
      sck = 1; mosi = 0; cs_ag = 1; cs_m = 1;
      errors = 0; checked = 0; bursts = 0; rx_bytes = 0; ignored = 0;
    endfunction

    function void set_cs(bit level);
      if (dev_sel) cs_m = level;
      else cs_ag = level;
    endfunction

    function srm_pkg::result_t apply_command(srm_pkg::item_t it);
      srm_pkg::result_t r;
      logic [7:0] tx;
      r = '0;
      case (it.func)
        srm_pkg::FUNC_LOAD: begin
          if (active || fill >= 4'(MAX_BYTES)) begin
            r.rejected = 1'b1;
          end else begin
            tx_buf[fill[IDX_W-1:0]] = it.wr_byte;
            fill++;
            if (32'(fill) > loaded_upto) loaded_upto = 32'(fill);
          end
        end
        srm_pkg::FUNC_START: begin
          if (active) begin
            r.rejected = 1'b1;
          end else begin
            active = 1; dev_sel = it.device; rd_mode = it.is_read;
            hdr_sr = {it.is_read, it.reg_addr};
            left = (it.burst_len > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : it.burst_len;
            byte_idx = '0; bit_idx = '0; in_hdr = 1; half_hi = 0; rx_sr = '0;
            if (!it.is_read) fill = '0;
            bursts++;
          end
        end
        srm_pkg::FUNC_TICK: begin
          if (active) begin
            if (dev_sel ? cs_m : cs_ag) begin
              set_cs(0);
            end else if (!in_hdr && left == 0) begin
              set_cs(1);
              active = 0;
              half_hi = 0;
            end else if (!half_hi) begin
              // falling edge: next data bit goes out
              sck = 0;
              if (in_hdr) begin
                mosi = hdr_sr[7];
              end else if (!rd_mode) begin
                tx = (byte_idx < 4'(MAX_BYTES)) ? tx_buf[byte_idx[IDX_W-1:0]] : 8'h00;
                mosi = tx[3'd7 - bit_idx[2:0]];
              end
              half_hi = 1;
            end else begin
              sck = 1;
              half_hi = 0;
              if (in_hdr) begin
                hdr_sr = hdr_sr << 1;
                bit_idx++;
                if (bit_idx >= 8) begin
                  bit_idx = '0;
                  in_hdr = 0;
                end
              end else begin
                if (rd_mode) rx_sr = {rx_sr[6:0], dev_sel ? it.miso_m : it.miso_ag};
                bit_idx++;
                if (bit_idx >= 8) begin
                  bit_idx = '0;
                  byte_idx++;
                  left--;
                  if (rd_mode) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte = rx_sr;
                    r.rx_last = (left == 0);
                    rx_sr = '0;
                    rx_bytes++;
                  end
                end
              end
            end
          end
        end
        default: r.rejected = 1'b1;
      endcase
      r.sck = sck;
      r.mosi = mosi;
      r.cs_ag_n = cs_ag;
      r.cs_m_n = cs_m;
      r.busy_res = active;
      return r;
    endfunction

    // returns 1 when the command did something (not rejected, not an idle tick)
    function bit note_command(srm_pkg::item_t it);
      srm_pkg::result_t r;
      bit idle_tick;
      idle_tick = (it.func == srm_pkg::FUNC_TICK) && !active;
      r = apply_command(it);
      pin_expect_q.push_back(r);
      if (r.rejected || idle_tick) begin
        ignored++;
        return 0;
      end
      return 1;
    endfunction

    function string diff_field(string nm, logic [7:0] want, logic [7:0] got);
      if (want !== got) return $sformatf(" %s exp %0h got %0h", nm, want, got);
      return "";
    endfunction

    function void check_pins(srm_pkg::result_t got);
      srm_pkg::result_t want;
      string msg;
      checked++;
      if (pin_expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("transfer %0d: result with nothing pending", checked);
        return;
      end
      want = pin_expect_q.pop_front();
      msg = {diff_field("sck", 8'(want.sck), 8'(got.sck)),
             diff_field("mosi", 8'(want.mosi), 8'(got.mosi)),
             diff_field("cs_ag_n", 8'(want.cs_ag_n), 8'(got.cs_ag_n)),
             diff_field("cs_m_n", 8'(want.cs_m_n), 8'(got.cs_m_n)),
             diff_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid)),
             diff_field("rx_byte", want.rx_byte, got.rx_byte),
             diff_field("rx_last", 8'(want.rx_last), 8'(got.rx_last)),
             diff_field("busy_res", 8'(want.busy_res), 8'(got.busy_res)),
             diff_field("rejected", 8'(want.rejected), 8'(got.rejected))};
      if (msg != "") begin
        errors++;
        if (errors <= 10) $display("transfer %0d mismatch:%s", checked, msg);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic in_device = 1'b0;
  logic in_is_read = 1'b0;
  logic [6:0] in_reg_addr = '0;
  logic [3:0] in_burst_len = '0;
  logic [7:0] in_wr_byte = '0;
  logic in_miso_ag = 1'b0;
  logic in_miso_m = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_sck, out_mosi, out_cs_ag_n, out_cs_m_n;
  logic out_rx_valid, out_rx_last, out_busy_res, out_rejected;
  logic [7:0] out_rx_byte;

  burst_scoreboard sb = new();
  int unsigned idle_odds = 0;  // 0: no idling, else one chance in idle_odds
  int unsigned useful_cmds = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;

  spi_register_access_master_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_device    (in_device),
    .in_is_read   (in_is_read),
    .in_reg_addr  (in_reg_addr),
    .in_burst_len (in_burst_len),
    .in_wr_byte   (in_wr_byte),
    .in_miso_ag   (in_miso_ag),
    .in_miso_m    (in_miso_m),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sck      (out_sck),
    .out_mosi     (out_mosi),
    .out_cs_ag_n  (out_cs_ag_n),
    .out_cs_m_n   (out_cs_m_n),
    .out_rx_valid (out_rx_valid),
    .out_rx_byte  (out_rx_byte),
    .out_rx_last  (out_rx_last),
    .out_busy_res (out_busy_res),
    .out_rejected (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               sb.pin_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_pins({out_sck, out_mosi, out_cs_ag_n, out_cs_m_n, out_rx_valid,
                     out_rx_byte, out_rx_last, out_busy_res, out_rejected});
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left <= $urandom_range(1, 8) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic srm_pkg::item_t rand_item();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(srm_pkg::item_t)-1:0];
  endfunction

  // call right after a rising edge; returns after the transfer edge
  task automatic send_item(srm_pkg::item_t it);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_device <= it.device;
    in_is_read <= it.is_read;
    in_reg_addr <= it.reg_addr;
    in_burst_len <= it.burst_len;
    in_wr_byte <= it.wr_byte;
    in_miso_ag <= it.miso_ag;
    in_miso_m <= it.miso_m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_command(it)) useful_cmds++;
  endtask

  // tick until chip select rises; pattern gives 0xFF then 0x00 on reads
  task automatic tick_until_idle(bit noisy, bit pattern);
    srm_pkg::item_t it;
    while (sb.active) begin
      it = rand_item();
      it.func = srm_pkg::FUNC_TICK;
      if (noisy && $urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 2))
          0: it.func = srm_pkg::FUNC_LOAD;
          1: it.func = srm_pkg::FUNC_START;
          default: it.func = FUNC_UNUSED;
        endcase
      end
      if (pattern) {it.miso_ag, it.miso_m} = {2{sb.byte_idx == 0}};
      send_item(it);
    end
  endtask

  task automatic random_burst();
    srm_pkg::item_t it, cmd;
    int unsigned lim;
    if ($urandom_range(0, 7) == 0) begin
      it = rand_item();
      it.func = $urandom_range(0, 1) ? FUNC_UNUSED : srm_pkg::FUNC_TICK;
      send_item(it);
    end
    cmd = rand_item();
    cmd.func = srm_pkg::FUNC_START;
    if (!cmd.is_read || $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(0, MAX_BYTES - int'(sb.fill))) begin
        it = rand_item();
        it.func = srm_pkg::FUNC_LOAD;
        send_item(it);
      end
      if (sb.fill == 4'(MAX_BYTES) && $urandom_range(0, 3) == 0) begin
        it = rand_item();
        it.func = srm_pkg::FUNC_LOAD;
        send_item(it);
      end
    end
    // a write may only send entries that were loaded at some point
    lim = cmd.is_read ? 15 : sb.loaded_upto;
    if (lim >= MAX_BYTES) lim = 15;
    if ($urandom_range(0, 3) != 0) cmd.burst_len = 4'($urandom_range(0, (lim < 2) ? lim : 2));
    else cmd.burst_len = 4'($urandom_range(0, lim));
    send_item(cmd);
    tick_until_idle(1'b1, 1'b0);
  endtask

  initial begin
    srm_pkg::item_t it;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    idle_odds = 6;
    it = rand_item(); it.func = FUNC_UNUSED; send_item(it);
    it = rand_item(); it.func = srm_pkg::FUNC_TICK; send_item(it);
    for (int i = 0; i < 8; i++) begin
      it = rand_item(); it.func = srm_pkg::FUNC_LOAD; it.wr_byte = EDGE_BYTES[i];
      send_item(it);
    end
    it = rand_item(); it.func = srm_pkg::FUNC_LOAD; send_item(it);  // buffer full
    it = rand_item(); it.func = srm_pkg::FUNC_START; it.device = 1'b1; it.is_read = 1'b0;
    it.reg_addr = 7'h7F; it.burst_len = 4'hF;  // count saturates
    send_item(it);
    it = rand_item(); it.func = srm_pkg::FUNC_START; send_item(it);  // busy
    it = rand_item(); it.func = srm_pkg::FUNC_LOAD; send_item(it);   // busy
    tick_until_idle(1'b0, 1'b0);
    it = rand_item(); it.func = srm_pkg::FUNC_START; it.device = 1'b0; it.is_read = 1'b0;
    it.reg_addr = 7'h00; it.burst_len = 4'h0;  // header only
    send_item(it);
    tick_until_idle(1'b0, 1'b0);
    it = rand_item(); it.func = srm_pkg::FUNC_START; it.device = 1'b1; it.is_read = 1'b1;
    it.reg_addr = 7'h55; it.burst_len = 4'h2;
    send_item(it);
    tick_until_idle(1'b0, 1'b1);

    // random bursts; the tail runs without idling
    useful_cmds = 0;
    while (useful_cmds < RANDOM_CMDS) begin
      if (useful_cmds < RANDOM_CMDS * 85 / 100) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 12;
        endcase
      end else begin
        idle_odds = 0;
      end
      random_burst();
    end
    in_valid <= 1'b0;
    idle_odds = 0;

    while (sb.pin_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bursts, %0d read bytes, %0d ignored commands, %0d transfers checked",
             sb.bursts, sb.rx_bytes, sb.ignored, sb.checked);
    $display("%0d mismatches, %0d results never seen", sb.errors, sb.pin_expect_q.size());
    if (sb.errors == 0 && sb.pin_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
